[rtl/assert_macros.svh]
// Concurrent assertion helpers, sampled on the rising clock edge and
// disabled while the active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_PROP(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

`define ASSERT_IMPL(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_PROP(name, clk, rstn, prop)
`define ASSERT_IMPL(name, clk, rstn, ante, cons)
`define ASSERT_NEXT(name, clk, rstn, ante, cons)

`endif

`endif

[rtl/umr_pkg.sv]
`timescale 1ns / 1ps
package umr_pkg;

  localparam int PULSE_W    = 17;
  localparam int THR_W      = 16;
  localparam int DIST_W     = 16;
  localparam int CNT_W      = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;
  localparam int MUL_W      = 9;
  localparam int PROD_W     = PULSE_W + MUL_W;
  localparam int DIST_SHIFT = 10;

  localparam logic [CFG_IDX_W-1:0] REG_NEAR_THR  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE = 1'd1;

  localparam logic [THR_W-1:0]   NEAR_THR_RST  = 16'd1600;
  localparam logic [PULSE_W-1:0] MAX_PULSE_RST = 17'd100000;

  localparam logic [MUL_W-1:0]  DIST_MUL   = 9'd281;
  localparam logic [PROD_W-1:0] DIST_ROUND = 26'd512;

  typedef struct packed {
    logic capture;
    logic step;
    logic rd_med;
    logic mul;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic ok;
    logic ins_more;
    logic set_full;
    logic out_free;
  } sts_t;

endpackage

[rtl/umr_ctrl.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module umr_ctrl
  import umr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_INSERT = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_MUL    = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_INSERT;
        end
      end
      S_INSERT: begin
        if (sts_i.ok) begin
          cmd_o.step = 1'b1;
        end
        if (!sts_i.ok || !sts_i.ins_more) begin
          state_d = sts_i.set_full ? S_READ : S_IDLE;
        end
      end
      S_READ: begin
        cmd_o.rd_med = 1'b1;
        state_d      = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `ASSERT_IMPL(a_emit_free, clk_i, rst_ni, cmd_o.emit, sts_i.out_free)
  `ASSERT_NEXT(a_read_then_mul, clk_i, rst_ni, cmd_o.rd_med, cmd_o.mul)
  `ASSERT_PROP(a_state_legal, clk_i, rst_ni, state_q <= S_EMIT)

endmodule

[rtl/umr_datapath.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module umr_datapath
  import umr_pkg::*;
#(
  parameter int SAMPLES_PER_SET = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [PULSE_W-1:0]    pulse_us_i,
  input  logic                  timed_out_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic                  result_valid_o,
  output logic [DIST_W-1:0]     distance_q4_o,
  output logic                  too_close_o,
  output logic [CNT_W-1:0]      valid_count_o,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o
);

  localparam int IDX_W = (SAMPLES_PER_SET > 1) ? $clog2(SAMPLES_PER_SET) : 1;
  localparam logic [CNT_W-1:0] SET_LEN = CNT_W'(SAMPLES_PER_SET);

  logic [THR_W-1:0]   near_thr_q;
  logic [PULSE_W-1:0] max_pulse_q;

  logic [PULSE_W-1:0] mem [SAMPLES_PER_SET];
  logic [PULSE_W-1:0] rd_q;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [PULSE_W-1:0] wr_data;

  logic [PULSE_W-1:0] pulse_q;
  logic               ok_q;
  logic [IDX_W-1:0]   ptr_q, ptr_d;
  logic [CNT_W-1:0]   cnt_q;
  logic [CNT_W-1:0]   seen_q;
  logic [PROD_W-1:0]  prod_q;
  logic [PROD_W-1:0]  dist_sum;
  logic               ins_more;
  logic               res_valid;

  logic               out_valid_q;
  logic               result_valid_q;
  logic [DIST_W-1:0]  distance_q;
  logic               too_close_q;
  logic [CNT_W-1:0]   valid_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_thr_q  <= NEAR_THR_RST;
      max_pulse_q <= MAX_PULSE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_NEAR_THR:  near_thr_q  <= cfg_data_i[THR_W-1:0];
        REG_MAX_PULSE: max_pulse_q <= cfg_data_i[PULSE_W-1:0];
        default: ;
      endcase
    end
  end

  assign ins_more = (ptr_q != '0) && (rd_q > pulse_q);

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.capture) begin
      ptr_d = cnt_q[IDX_W-1:0];
    end else if (cmd_i.step && ins_more) begin
      ptr_d = ptr_q - 1'b1;
    end
  end

  always_comb begin
    if (cmd_i.rd_med) begin
      rd_addr = IDX_W'(cnt_q >> 1);
    end else if (ptr_d != '0) begin
      rd_addr = ptr_d - 1'b1;
    end else begin
      rd_addr = '0;
    end
  end

  assign wr_en   = cmd_i.step;
  assign wr_data = ins_more ? rd_q : pulse_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[ptr_q] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pulse_q <= pulse_us_i;
    end
    ptr_q <= ptr_d;
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(rd_q) * PROD_W'(DIST_MUL);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q   <= 1'b0;
      cnt_q  <= '0;
      seen_q <= '0;
    end else begin
      if (cmd_i.capture) begin
        ok_q   <= !timed_out_i && (pulse_us_i != '0) && (pulse_us_i <= max_pulse_q)
                  && (cnt_q < SET_LEN);
        seen_q <= seen_q + 1'b1;
      end
      if (cmd_i.step && !ins_more) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.emit) begin
        cnt_q  <= '0;
        seen_q <= '0;
      end
    end
  end

  assign dist_sum  = prod_q + DIST_ROUND;
  assign res_valid = (cnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      result_valid_q <= res_valid;
      distance_q     <= res_valid ? dist_sum[DIST_SHIFT +: DIST_W] : '0;
      too_close_q    <= res_valid && (dist_sum[DIST_SHIFT +: DIST_W] < near_thr_q);
      valid_count_q  <= cnt_q;
    end
  end

  assign sts_o.ok       = ok_q;
  assign sts_o.ins_more = ins_more;
  assign sts_o.set_full = (seen_q == SET_LEN);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign result_valid_o = result_valid_q;
  assign distance_q4_o  = distance_q;
  assign too_close_o    = too_close_q;
  assign valid_count_o  = valid_count_q;

  `ASSERT_PROP(a_cnt_le_seen, clk_i, rst_ni, cnt_q <= seen_q)
  `ASSERT_PROP(a_seen_bound, clk_i, rst_ni, seen_q <= SET_LEN)
  `ASSERT_NEXT(a_emit_clears, clk_i, rst_ni, cmd_i.emit, (cnt_q == '0) && out_valid_q)

endmodule

[rtl/ultrasonic_median_ranger.sv]
`timescale 1ns / 1ps
// Channel   Handshake                  Payload
// input     in_valid_i / in_ready_o    pulse_us_i, timed_out_i
// output    out_valid_o / out_ready_i  result_valid_o, distance_q4_o, too_close_o,
//                                      valid_count_o
// config    cfg_we_i                   cfg_idx_i, cfg_data_i
//
// A transaction is a capture followed by the steps of the sorted insertion, which
// walks the sample memory one entry a cycle. The last transaction of a set adds a
// median read, a multiply and a result load. Input is taken while a result waits;
// the end of the next set holds until it drains. Reset is asynchronous, active low;
// the sample memory needs no clearing.
module ultrasonic_median_ranger
  import umr_pkg::*;
#(
  parameter int SAMPLES_PER_SET = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [PULSE_W-1:0]    pulse_us_i,
  input  logic                  timed_out_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  result_valid_o,
  output logic [DIST_W-1:0]     distance_q4_o,
  output logic                  too_close_o,
  output logic [CNT_W-1:0]      valid_count_o
);

  cmd_t cmd;
  sts_t sts;

  umr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  umr_datapath #(
    .SAMPLES_PER_SET (SAMPLES_PER_SET)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .pulse_us_i     (pulse_us_i),
    .timed_out_i    (timed_out_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .result_valid_o (result_valid_o),
    .distance_q4_o  (distance_q4_o),
    .too_close_o    (too_close_o),
    .valid_count_o  (valid_count_o),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

endmodule
